@@ hdl/base64_hash_candidate_check_defines.svh @@
// Assertion macros for the base64 hash candidate checker.
// Depends on nothing; the asserting module supplies clk and rst_n.
`ifndef BASE64_HASH_CANDIDATE_CHECK_DEFINES_SVH
`define BASE64_HASH_CANDIDATE_CHECK_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define B64HC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64hc assertion failed");
// next-cycle implication
`define B64HC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64hc assertion failed");
`else
`define B64HC_ASSERT_IMP(lbl, ante, cons)
`define B64HC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/b64hc_pkg.sv @@
// Types, constants and helper functions for the base64 hash candidate checker.
// No dependencies.
package b64hc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } st_t;

  // character classes; codes 5 and 7 unused
  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_UPPER = 3'd1,
    CLS_LOWER = 3'd2,
    CLS_DIGIT = 3'd3,
    CLS_PLUS  = 3'd4,
    CLS_SLASH = 3'd6
  } cls_t;

  localparam int unsigned DigitIndexBase = 26 + 26;
  localparam int unsigned PlusIndex      = 26 + 26 + 10;
  localparam int unsigned SlashIndex     = 26 + 26 + 10 + 1;

  localparam logic [7:0] DELTA_UPPER = 8'(0 - 65);
  localparam logic [7:0] DELTA_LOWER = 8'(26 - 97);
  localparam logic [7:0] DELTA_DIGIT = 8'(DigitIndexBase - 48);
  localparam logic [7:0] DELTA_PLUS  = 8'(PlusIndex - 43);
  localparam logic [7:0] DELTA_SLASH = 8'(SlashIndex - 47);
  localparam logic [7:0] DELTA_EMPTY = 8'h00;
  localparam logic [7:0] CHECK_EMPTY = 8'h80;   // most negative signed byte

  function automatic cls_t class_of(input logic [6:0] c);
    cls_t r;
    r = CLS_NONE;
    if (c >= 7'h41 && c <= 7'h5a)      r = CLS_UPPER;
    else if (c >= 7'h61 && c <= 7'h7a) r = CLS_LOWER;
    else if (c >= 7'h30 && c <= 7'h39) r = CLS_DIGIT;
    else if (c == 7'h2b)               r = CLS_PLUS;
    else if (c == 7'h2f)               r = CLS_SLASH;
    return r;
  endfunction

  function automatic logic [7:0] delta_of(input cls_t cls);
    logic [7:0] r;
    unique case (cls)
      CLS_UPPER: r = DELTA_UPPER;
      CLS_LOWER: r = DELTA_LOWER;
      CLS_DIGIT: r = DELTA_DIGIT;
      CLS_PLUS:  r = DELTA_PLUS;
      CLS_SLASH: r = DELTA_SLASH;
      default:   r = DELTA_EMPTY;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/base64_hash_candidate_check.sv @@
// Base64 decoding hash candidate checker, top level.
// Depends on b64hc_pkg and base64_hash_candidate_check_defines.svh.
//
// Usage notes:
// - Input channel (in_valid/in_ready/in_candidate): one word is one 64-bit
//   candidate, nibble k being the association value of codes c with c mod 16 = k.
// - Output channel (out_valid/out_ready/out_*): a failing candidate yields one
//   word (ok 0, bucket 0, value 0, last 1); a passing one yields sixteen words,
//   buckets 0..15 in order, last set on bucket 15.
// - cfg_we/cfg_wdata write check_mode (0 delta table, 1 check table); write it
//   only while the block is idle.
// - Operation: accept, then a scan of every 7-bit ASCII code (one code per cycle
//   through the single bucket/compare unit and the 16-entry table), then one
//   word per cycle while the receiver takes them. in_ready is high only when
//   idle.
// - A finished result in the output register does not block the next accept;
//   when the receiver stalls the output register holds, and emission waits.
// - Reset (synchronous, rst_n low) returns to idle, empties the output register,
//   clears the table valid bits and sets check_mode to delta.
`include "base64_hash_candidate_check_defines.svh"

module base64_hash_candidate_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_candidate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_ok,
  output logic [3:0]        out_bucket,
  output logic signed [7:0] out_table_value,
  output logic              out_last
);

  // control
  b64hc_pkg::st_t state_r, state_nxt;
  logic           mode_r;
  logic [6:0]     cnt_r, cnt_nxt;      // code during scan, bucket during emit
  logic           pass_r, pass_nxt;
  logic [63:0]    cand_r;

  // bucket table: per-entry valid flags plus payload (class or earliest code)
  logic [15:0]    vld_r;
  logic [6:0]     ent_r [16];
  logic           tbl_we;
  logic [3:0]     tbl_wa;
  logic [6:0]     tbl_wd;

  // output register
  logic           out_valid_r, out_valid_nxt;
  logic           out_ok_r, out_ok_nxt;
  logic [3:0]     out_bucket_r, out_bucket_nxt;
  logic [7:0]     out_value_r, out_value_nxt;
  logic           out_last_r, out_last_nxt;

  // shared scan unit: bucket index and class of the current code
  logic [3:0]           nib;
  logic [4:0]           bsum;
  logic [3:0]           bkt;
  b64hc_pkg::cls_t      cls;
  logic                 hit;
  logic [6:0]           ent;
  logic [3:0]           ek;
  logic [6:0]           eent;
  logic                 evld;
  logic                 slot_free;
  logic                 accept;

  assign accept    = in_valid && in_ready;
  assign nib       = cand_r[{cnt_r[3:0], 2'b00} +: 4];
  assign bsum      = {1'b0, cnt_r[6:3]} + {1'b0, nib} + 5'd1;
  assign bkt       = bsum[4:1];
  assign cls       = b64hc_pkg::class_of(cnt_r);
  assign hit       = vld_r[bkt];
  assign ent       = ent_r[bkt];
  assign ek        = cnt_r[3:0];
  assign eent      = ent_r[ek];
  assign evld      = vld_r[ek];
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pass_nxt       = pass_r;
    tbl_we         = 1'b0;
    tbl_wa         = bkt;
    tbl_wd         = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_ok_nxt     = out_ok_r;
    out_bucket_nxt = out_bucket_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    in_ready       = 1'b0;
    unique case (state_r)
      b64hc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = b64hc_pkg::ST_SCAN;
          cnt_nxt   = '0;
          pass_nxt  = 1'b1;
        end
      end
      b64hc_pkg::ST_SCAN: begin
        if (!mode_r) begin
          // delta: all valid codes of a bucket share one class
          if (cls != b64hc_pkg::CLS_NONE) begin
            if (hit) begin
              if (ent != {4'b0000, cls}) pass_nxt = 1'b0;
            end else begin
              tbl_we = 1'b1;
              tbl_wd = {4'b0000, cls};
            end
          end
        end else begin
          // check: first valid code is kept; an invalid one after it fails
          if (cls != b64hc_pkg::CLS_NONE) begin
            tbl_we = !hit;
          end else if (hit) begin
            pass_nxt = 1'b0;
          end
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          state_nxt = b64hc_pkg::ST_EMIT;
        end
      end
      b64hc_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (!pass_r) begin
            out_ok_nxt     = 1'b0;
            out_bucket_nxt = '0;
            out_value_nxt  = 8'h00;
            out_last_nxt   = 1'b1;
            state_nxt      = b64hc_pkg::ST_IDLE;
          end else begin
            out_ok_nxt     = 1'b1;
            out_bucket_nxt = ek;
            if (!mode_r)
              out_value_nxt = evld ? b64hc_pkg::delta_of(b64hc_pkg::cls_t'(eent[2:0]))
                                   : b64hc_pkg::DELTA_EMPTY;
            else
              out_value_nxt = evld ? 8'(8'h00 - {1'b0, eent})
                                   : b64hc_pkg::CHECK_EMPTY;
            out_last_nxt   = (ek == 4'd15);
            cnt_nxt        = cnt_r + 7'd1;
            if (ek == 4'd15) state_nxt = b64hc_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = b64hc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b64hc_pkg::ST_IDLE;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      cnt_r       <= '0;
      pass_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pass_r      <= pass_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
      if (accept) vld_r <= '0;
      else if (tbl_we) vld_r[tbl_wa] <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (accept) cand_r <= in_candidate;
    if (tbl_we) ent_r[tbl_wa] <= tbl_wd;
    out_ok_r     <= out_ok_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_bucket      = out_bucket_r;
  assign out_table_value = signed'(out_value_r);
  assign out_last        = out_last_r;

  // a failing candidate's word is final and carries bucket 0
  `B64HC_ASSERT_IMP(a_fail_word, out_valid && !out_ok, out_last && out_bucket == 4'd0)
  // only bucket 15 closes a passing candidate
  `B64HC_ASSERT_IMP(a_pass_last, out_valid && out_ok && out_last, out_bucket == 4'd15)
  // an accepted word starts a scan at code 0
  `B64HC_ASSERT_NXT(a_scan_start, in_valid && in_ready, !in_ready && cnt_r == 7'd0)
  // the scan ends after code 127 and moves to emission
  `B64HC_ASSERT_NXT(a_scan_end, state_r == b64hc_pkg::ST_SCAN && cnt_r == 7'd127,
                    state_r == b64hc_pkg::ST_EMIT && cnt_r == 7'd0)

endmodule
